### rtl/ipfd_pkg.sv
// Shared types and constants for the incremental PID firing delay core.
// Depends on nothing; every RTL file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ipfd_pkg;

   // Field and datapath widths.
   localparam int CFG_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int TEMP_W    = 9;
   localparam int ERR_W     = 11;
   localparam int ACC_W     = 48;
   localparam int SUM_W     = 64;
   localparam int COEF_W    = 52;
   localparam int OP_W      = 33;
   localparam int PROD_W    = 66;
   localparam int FRAC_W    = 16;
   localparam int QUO_W     = 48;
   localparam int SCALED_W  = 51;
   localparam int TICKS_W   = 32;
   localparam int DRIVE_W   = 32;
   localparam int DELAY_W   = 17;
   localparam int RELOAD_W  = 16;

   // Divider: two quotient bits per cycle.
   localparam int DIV_STEPS = QUO_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Multiply-accumulate passes: three errors, low and high coefficient halves.
   localparam int MAC_STEPS = 6;
   localparam int MAC_CNT_W = $clog2(MAC_STEPS);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;

   // Register reset values.
   localparam logic [CFG_W-1:0] PROP_GAIN_RESET     = 32'd1966080;
   localparam logic [CFG_W-1:0] INTEG_GAIN_RESET    = 32'd655;
   localparam logic [CFG_W-1:0] DERIV_GAIN_RESET    = 32'd0;
   localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RESET = 32'd32768;

   // Accumulator limits, Q31.16.
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // Firing delay and timer arithmetic, all in Q.16.
   localparam logic signed [ACC_W:0]  DELAY_BASE   = 49'sd393216000;  // 6000.0
   localparam logic [SCALED_W-1:0]    DELAY_OFFSET = 51'd65536000;    // 1000.0
   localparam int                     TICK_SHIFT   = 19;
   localparam logic [SCALED_W-1:0]    TICK_ROUND   = 51'd524287;
   localparam logic [DELAY_W-1:0]     DELAY_INT_MAX = 17'h1FFFF;

   // Control word of the shared multiply-accumulate unit.
   typedef struct packed {
      logic mul_en;    // multiply the operands this cycle
      logic shift_hi;  // product belongs to the upper coefficient half
      logic acc_load;  // load the accumulator with the start value
   } mac_ctrl_type;

endpackage

`default_nettype wire

### rtl/ipfd_div.sv
// Iterative unsigned divider, 48-bit dividend by 32-bit divisor, two bits a cycle.
// Depends on ipfd_pkg for widths and the step count.
`timescale 1ns / 1ps
`default_nettype none

module ipfd_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [ipfd_pkg::QUO_W-1:0]  dividend,
   input  wire logic [ipfd_pkg::CFG_W-1:0]  divisor,
   output logic                             busy,
   output logic [ipfd_pkg::QUO_W-1:0]       quotient
);

   logic                              busy_ff, busy_in;
   logic [ipfd_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ipfd_pkg::CFG_W-1:0]        rem_ff, rem_in;
   logic [ipfd_pkg::QUO_W-1:0]        quo_ff, quo_in;
   logic [ipfd_pkg::CFG_W-1:0]        dvs_ff, dvs_in;
   logic [ipfd_pkg::CFG_W:0]          step_a, step_b;

   // One restoring step: quotient bit on top, new remainder below.
   function automatic logic [ipfd_pkg::CFG_W:0] div_step(
      input logic [ipfd_pkg::CFG_W-1:0] rem,
      input logic                       bit_in,
      input logic [ipfd_pkg::CFG_W-1:0] dvs
   );
      logic [ipfd_pkg::CFG_W+1:0] trial;
      trial = {1'b0, rem, bit_in} - {2'b00, dvs};
      if (trial[ipfd_pkg::CFG_W+1]) begin
         div_step = {1'b0, rem[ipfd_pkg::CFG_W-2:0], bit_in};
      end else begin
         div_step = {1'b1, trial[ipfd_pkg::CFG_W-1:0]};
      end
   endfunction

   // Two chained steps consume the top two dividend bits.
   always_comb begin
      step_a = div_step(rem_ff, quo_ff[ipfd_pkg::QUO_W-1], dvs_ff);
      step_b = div_step(step_a[ipfd_pkg::CFG_W-1:0], quo_ff[ipfd_pkg::QUO_W-2], dvs_ff);
   end

   // Sequencing of the iterations.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = step_b[ipfd_pkg::CFG_W-1:0];
         quo_in = {quo_ff[ipfd_pkg::QUO_W-3:0], step_a[ipfd_pkg::CFG_W],
                   step_b[ipfd_pkg::CFG_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ipfd_pkg::DIV_CNT_W'(ipfd_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### rtl/ipfd_mac.sv
// Shared 33 by 33 signed multiplier with a registered product and a 64-bit accumulator.
// Depends on ipfd_pkg for widths and the control word type.
`timescale 1ns / 1ps
`default_nettype none

module ipfd_mac (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire ipfd_pkg::mac_ctrl_type             ctrl,
   input  wire logic signed [ipfd_pkg::OP_W-1:0]   op_a,
   input  wire logic signed [ipfd_pkg::OP_W-1:0]   op_b,
   input  wire logic signed [ipfd_pkg::SUM_W-1:0]  load_value,
   output logic signed [ipfd_pkg::PROD_W-1:0]      product,
   output logic signed [ipfd_pkg::SUM_W-1:0]       acc
);

   logic signed [ipfd_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                               prod_vld_ff, prod_hi_ff;
   logic signed [ipfd_pkg::SUM_W-1:0]  acc_ff, acc_in;
   logic signed [ipfd_pkg::SUM_W-1:0]  addend;

   // The product is registered before it reaches the adder.
   always_comb begin
      prod_in = op_a * op_b;
      if (prod_hi_ff) begin
         addend = {prod_ff[31:0], 32'd0};
      end else begin
         addend = prod_ff[ipfd_pkg::SUM_W-1:0];
      end
      if (ctrl.acc_load) begin
         acc_in = load_value;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + addend;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.mul_en;
      end
      if (ctrl.mul_en) begin
         prod_ff    <= prod_in;
         prod_hi_ff <= ctrl.shift_hi;
      end
      acc_ff <= acc_in;
   end

   assign product = prod_ff;
   assign acc     = acc_ff;

endmodule

`default_nettype wire

### rtl/incremental_pid_firing_delay_core.sv
// Top level of the incremental PID firing delay core: sequencer, state and result word.
// Depends on ipfd_pkg, ipfd_div and ipfd_mac.
//
// Each request word carries a measured and a target temperature; the core answers with one
// response word holding the saturated PID drive level, the heater firing delay, the timer
// reload value and a heater-on flag. The next word can be accepted only once the previous one
// has left ST_FIN and the core is idle again. The division of the derivative gain by the sample
// period runs two quotient bits a cycle from acceptance, while the shared multiplier forms the
// integral product in ST_HALF as the division begins. ST_DIV then waits for the divider to
// finish, ST_COEF builds the coefficients, six passes go through the shared multiply-accumulate
// unit in ST_MAC, ST_DRAIN adds the last product, and ST_SAT, ST_DLY, ST_TICK and ST_FIN
// saturate, form the delay, scale it and load the response word. The core takes one request
// word at a time and accepts the next one while a finished response word still waits to be
// taken; that next word then holds in its last step until the earlier response word has gone.
// Gain registers are written through the csr_ port and should only be changed while no word
// is in progress.
`timescale 1ns / 1ps
`default_nettype none

module incremental_pid_firing_delay_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [ipfd_pkg::TEMP_W-1:0]          req_measured_temp,
   input  wire logic [ipfd_pkg::TEMP_W-1:0]          req_target_temp,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [ipfd_pkg::DRIVE_W-1:0]       rsp_drive_level,
   output logic [ipfd_pkg::DELAY_W-1:0]              rsp_firing_delay,
   output logic [ipfd_pkg::RELOAD_W-1:0]             rsp_timer_reload,
   output logic                                      rsp_heater_on,
   input  wire logic                                 csr_wr_en,
   input  wire logic [ipfd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ipfd_pkg::CFG_W-1:0]           csr_wr_data
);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_HALF  = 10'b0000000010,
      ST_DIV   = 10'b0000000100,
      ST_COEF  = 10'b0000001000,
      ST_MAC   = 10'b0000010000,
      ST_DRAIN = 10'b0000100000,
      ST_SAT   = 10'b0001000000,
      ST_DLY   = 10'b0010000000,
      ST_TICK  = 10'b0100000000,
      ST_FIN   = 10'b1000000000
   } state_type;

   state_type                                 state_ff, state_in;
   logic [ipfd_pkg::CFG_W-1:0]                prop_gain_ff, integ_gain_ff;
   logic [ipfd_pkg::CFG_W-1:0]                deriv_gain_ff, sample_period_ff;
   logic signed [ipfd_pkg::ERR_W-1:0]         err_ff, err_in;
   logic                                      heater_ff, heater_in;
   logic signed [ipfd_pkg::ERR_W-1:0]         last_err_ff, older_err_ff;
   logic signed [ipfd_pkg::ACC_W-1:0]         prev_out_ff;
   logic signed [ipfd_pkg::COEF_W-1:0]        a1_ff, a2_ff, a3_ff, a1_in, a2_in, a3_in;
   logic [ipfd_pkg::MAC_CNT_W-1:0]            step_ff, step_in;
   logic signed [ipfd_pkg::ACC_W-1:0]         sat_ff, sat_in;
   logic [ipfd_pkg::ACC_W-1:0]                delay_ff, delay_in;
   logic [ipfd_pkg::SCALED_W-1:0]             scaled_ff, scaled_in;
   logic                                      rsp_valid_ff, rsp_valid_in;
   logic signed [ipfd_pkg::DRIVE_W-1:0]       drive_ff;
   logic [ipfd_pkg::DELAY_W-1:0]              fdelay_ff, fdelay_in;
   logic [ipfd_pkg::RELOAD_W-1:0]             reload_ff, reload_in;
   logic                                      rheater_ff;

   logic                                      accept, fin_go, div_busy;
   logic [ipfd_pkg::CFG_W-1:0]                divisor;
   logic [ipfd_pkg::QUO_W-1:0]                quotient;
   ipfd_pkg::mac_ctrl_type                    mac_ctrl;
   logic signed [ipfd_pkg::OP_W-1:0]          op_a, op_b;
   logic signed [ipfd_pkg::SUM_W-1:0]         mac_load;
   logic signed [ipfd_pkg::PROD_W-1:0]        product;
   logic signed [ipfd_pkg::SUM_W-1:0]         acc;
   logic signed [ipfd_pkg::ERR_W-1:0]         err_sel;
   logic signed [ipfd_pkg::COEF_W-1:0]        coef_sel;
   logic signed [ipfd_pkg::COEF_W-1:0]        kp_ext, half_ext, dt_ext;
   logic signed [ipfd_pkg::ACC_W:0]           delay_diff;
   logic [ipfd_pkg::SCALED_W-1:0]             delay_sum, rounded;
   logic [ipfd_pkg::TICKS_W-1:0]              ticks;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= ipfd_pkg::PROP_GAIN_RESET;
         integ_gain_ff    <= ipfd_pkg::INTEG_GAIN_RESET;
         deriv_gain_ff    <= ipfd_pkg::DERIV_GAIN_RESET;
         sample_period_ff <= ipfd_pkg::SAMPLE_PERIOD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ipfd_pkg::REG_PROP_GAIN:     prop_gain_ff     <= csr_wr_data;
            ipfd_pkg::REG_INTEG_GAIN:    integ_gain_ff    <= csr_wr_data;
            ipfd_pkg::REG_DERIV_GAIN:    deriv_gain_ff    <= csr_wr_data;
            ipfd_pkg::REG_SAMPLE_PERIOD: sample_period_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Handshake on both sides.
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign fin_go    = (state_ff == ST_FIN) & (~rsp_valid_ff | rsp_ready);

   // A zero sample period divides as one least significant bit.
   assign divisor = (sample_period_ff == '0) ? ipfd_pkg::CFG_W'(1) : sample_period_ff;

   ipfd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend ({deriv_gain_ff, {ipfd_pkg::FRAC_W{1'b0}}}),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // Error and heater flag of the incoming word.
   always_comb begin
      err_in    = {2'b00, req_target_temp} - {2'b00, req_measured_temp};
      heater_in = (req_measured_temp <= req_target_temp);
   end

   // Coefficients from the gains, the integral product and the quotient.
   always_comb begin
      kp_ext   = {20'd0, prop_gain_ff};
      half_ext = {5'd0, product[63:17]};
      dt_ext   = {4'd0, quotient};
      a1_in    = kp_ext + half_ext + dt_ext;
      a2_in    = half_ext - kp_ext - {dt_ext[ipfd_pkg::COEF_W-2:0], 1'b0};
      a3_in    = dt_ext;
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (step_ff[2:1])
         2'd0: begin
            err_sel  = err_ff;
            coef_sel = a1_ff;
         end
         2'd1: begin
            err_sel  = last_err_ff;
            coef_sel = a2_ff;
         end
         2'd2: begin
            err_sel  = older_err_ff;
            coef_sel = a3_ff;
         end
         default: begin
            err_sel  = '0;
            coef_sel = '0;
         end
      endcase
      if (state_ff == ST_HALF) begin
         op_a = {1'b0, integ_gain_ff};
         op_b = {1'b0, sample_period_ff};
      end else begin
         op_a = {{(ipfd_pkg::OP_W-ipfd_pkg::ERR_W){err_sel[ipfd_pkg::ERR_W-1]}}, err_sel};
         if (step_ff[0]) begin
            op_b = {{13{coef_sel[ipfd_pkg::COEF_W-1]}}, coef_sel[ipfd_pkg::COEF_W-1:32]};
         end else begin
            op_b = {1'b0, coef_sel[31:0]};
         end
      end
      mac_ctrl.mul_en   = (state_ff == ST_HALF) | (state_ff == ST_MAC);
      mac_ctrl.shift_hi = (state_ff == ST_MAC) & step_ff[0];
      mac_ctrl.acc_load = (state_ff == ST_COEF);
      mac_load = {{(ipfd_pkg::SUM_W-ipfd_pkg::ACC_W){prev_out_ff[ipfd_pkg::ACC_W-1]}},
                  prev_out_ff};
   end

   ipfd_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .op_a       (op_a),
      .op_b       (op_b),
      .load_value (mac_load),
      .product    (product),
      .acc        (acc)
   );

   // Saturation, firing delay and timer arithmetic.
   always_comb begin
      if ((&acc[63:47]) | (~|acc[63:47])) begin
         sat_in = acc[ipfd_pkg::ACC_W-1:0];
      end else if (acc[63]) begin
         sat_in = ipfd_pkg::ACC_MIN;
      end else begin
         sat_in = ipfd_pkg::ACC_MAX;
      end

      delay_diff = ipfd_pkg::DELAY_BASE - {sat_ff[ipfd_pkg::ACC_W-1], sat_ff};
      if (delay_diff[ipfd_pkg::ACC_W]) begin
         delay_in = '0;
      end else begin
         delay_in = delay_diff[ipfd_pkg::ACC_W-1:0];
      end

      delay_sum = ipfd_pkg::DELAY_OFFSET + {3'd0, delay_ff};
      scaled_in = delay_sum + {delay_sum[ipfd_pkg::SCALED_W-3:0], 2'b00};

      rounded = scaled_ff + ipfd_pkg::TICK_ROUND;
      ticks   = rounded[ipfd_pkg::SCALED_W-1:ipfd_pkg::TICK_SHIFT];
      if (|ticks[31:16]) begin
         reload_in = '0;
      end else begin
         reload_in = ipfd_pkg::RELOAD_W'(17'h10000 - {1'b0, ticks[15:0]});
      end

      if (|delay_ff[47:33]) begin
         fdelay_in = ipfd_pkg::DELAY_INT_MAX;
      end else begin
         fdelay_in = delay_ff[32:16];
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_HALF;
            end
         end
         ST_HALF:  state_in = ST_DIV;
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_COEF;
            end
         end
         ST_COEF: begin
            state_in = ST_MAC;
            step_in  = '0;
         end
         ST_MAC: begin
            step_in = step_ff + 1'b1;
            if (step_ff == ipfd_pkg::MAC_CNT_W'(ipfd_pkg::MAC_STEPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_SAT;
         ST_SAT:   state_in = ST_DLY;
         ST_DLY:   state_in = ST_TICK;
         ST_TICK:  state_in = ST_FIN;
         ST_FIN: begin
            if (fin_go) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase

      if (fin_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state and controller history.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         last_err_ff  <= '0;
         older_err_ff <= '0;
         prev_out_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_SAT) begin
            prev_out_ff  <= sat_in;
            older_err_ff <= last_err_ff;
            last_err_ff  <= err_ff;
         end
      end
   end

   // Working registers and the response word.
   always_ff @(posedge clock) begin
      if (accept) begin
         err_ff    <= err_in;
         heater_ff <= heater_in;
      end
      if (state_ff == ST_COEF) begin
         a1_ff <= a1_in;
         a2_ff <= a2_in;
         a3_ff <= a3_in;
      end
      if (state_ff == ST_SAT) begin
         sat_ff <= sat_in;
      end
      if (state_ff == ST_DLY) begin
         delay_ff <= delay_in;
      end
      if (state_ff == ST_TICK) begin
         scaled_ff <= scaled_in;
      end
      if (fin_go) begin
         drive_ff   <= sat_ff[ipfd_pkg::ACC_W-1:ipfd_pkg::FRAC_W];
         fdelay_ff  <= fdelay_in;
         reload_ff  <= reload_in;
         rheater_ff <= heater_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_level  = drive_ff;
   assign rsp_firing_delay = fdelay_ff;
   assign rsp_timer_reload = reload_ff;
   assign rsp_heater_on    = rheater_ff;

   // An accepted word starts the divider and the integral multiply at once.
   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_HALF) && div_busy)
      else $error("accepted word did not start the divider");

   // No new word may enter while the divider is still iterating.
   a_busy_blocks : assert property (@(posedge clock) disable iff (reset)
      div_busy |-> !req_ready)
      else $error("request accepted while the divider was busy");

   // The pass counter stays within the six multiply-accumulate passes.
   a_step_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> (step_ff < ipfd_pkg::MAC_CNT_W'(ipfd_pkg::MAC_STEPS)))
      else $error("multiply-accumulate pass counter out of range");

   // Finishing a word always presents a response word on the next cycle.
   a_fin_presents : assert property (@(posedge clock) disable iff (reset)
      fin_go |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished word was not presented");

endmodule

`default_nettype wire
